[design/olis_pkg.sv]
// shared types and codes for the ordered list with insert and search
package olis_pkg;

    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_INSERT     = 3'd4;
    localparam logic [2:0] ACT_SEARCH     = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_POS = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    localparam int GROUP_W = 8;

    // broadcast to every cell
    typedef struct packed {
        logic ins;
        logic drop_head;
    } cell_cmd_t;

    // scan unit status back to control
    typedef struct packed {
        logic done;
        logic found;
    } scan_stat_t;

endpackage

[design/olis_channels.sv]
// request and response channel interfaces
interface olis_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic signed [31:0] value;
    logic signed [7:0]  position;

    modport source (output valid, action, value, position, input ready);
    modport sink   (input valid, action, value, position, output ready);
endinterface

interface olis_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       found;
    logic [5:0] found_index;
    logic [6:0] length;

    modport source (output valid, status, found, found_index, length, input ready);
    modport sink   (input valid, status, found, found_index, length, output ready);
endinterface

[design/ordered_list_insert_search.sv]
// top level: bounded ordered list with push, pop, positional insert and search
//
//   channel  dir  payload                                  meaning
//   req      in   action, value, position                  one request item
//   rsp      out  status, found, found_index, length       one result item
//
// push, pop front and insert shift the cells together in the accept cycle; pop back only lowers the count.
// search: the match vector is walked eight entries per cycle by the scan unit
// until the first hit or the last group.
// one request at a time; the next is accepted once the result register is free.
// rst_n clears the entry count and the handshake state; entry storage is not cleared.
// a stalled rsp holds the result and blocks further requests.
module ordered_list_insert_search #(
    parameter int CAPACITY = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    olis_req_if.sink        req,
    olis_rsp_if.source      rsp
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int NG = (CAPACITY + olis_pkg::GROUP_W - 1) / olis_pkg::GROUP_W;
    localparam int GW = (NG > 1) ? $clog2(NG) : 1;
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                 state_reg;
    logic                 state_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;
    logic                 found_reg;
    logic                 found_next;
    logic [5:0]           fidx_reg;
    logic [5:0]           fidx_next;
    logic [6:0]           len_reg;
    logic [6:0]           len_next;

    logic                 out_free;
    logic                 in_fire;
    logic                 is_full;
    logic                 is_empty;
    logic                 pos_ok;
    logic [CW+6:0]        pos_cmp;
    logic [CW+6:0]        cnt_cmp;
    logic [IW+6:0]        pos_wide;
    logic [IW-1:0]        ins_pos;
    logic [6:0]           len_now;
    logic [CW+6:0]        len_wide;
    logic [GW+8:0]        idx_wide;

    olis_pkg::cell_cmd_t  cmd;
    olis_pkg::scan_stat_t scan_stat;
    logic                 scan_start;
    logic [GW+2:0]        scan_idx;
    logic [CAPACITY-1:0]  match_vec;
    logic [31:0]          cell_val [CAPACITY];

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign in_fire   = req.valid && req.ready;

    assign is_full  = (count_reg == FULL_CNT);
    assign is_empty = (count_reg == '0);
    assign pos_cmp  = {CW'(0), req.position[6:0]};
    assign cnt_cmp  = {7'd0, count_reg};
    assign pos_ok   = !req.position[7] && (pos_cmp <= cnt_cmp);
    assign pos_wide = {IW'(0), req.position[6:0]};

    assign len_wide = {7'd0, count_next};
    assign len_now  = len_wide[6:0];
    assign idx_wide = {6'd0, scan_idx};

    always_comb
    begin
        cmd.ins       = 1'b0;
        cmd.drop_head = 1'b0;
        ins_pos       = '0;
        count_next    = count_reg;
        scan_start    = 1'b0;
        state_next    = state_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        fidx_next     = fidx_reg;
        len_next      = len_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        if (in_fire)
        begin
            status_next    = olis_pkg::ST_OK;
            found_next     = 1'b0;
            fidx_next      = 6'd0;
            out_valid_next = 1'b1;
            case (req.action)
                olis_pkg::ACT_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = olis_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.ins    = 1'b1;
                        ins_pos    = '0;
                        count_next = count_reg + CW'(1);
                    end
                end
                olis_pkg::ACT_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = olis_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.ins    = 1'b1;
                        ins_pos    = IW'(count_reg);
                        count_next = count_reg + CW'(1);
                    end
                end
                olis_pkg::ACT_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = olis_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        cmd.drop_head = 1'b1;
                        count_next    = count_reg - CW'(1);
                    end
                end
                olis_pkg::ACT_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        status_next = olis_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                olis_pkg::ACT_INSERT:
                begin
                    if (!pos_ok)
                    begin
                        status_next = olis_pkg::ST_BAD_POS;
                    end
                    else if (is_full)
                    begin
                        status_next = olis_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.ins    = 1'b1;
                        ins_pos    = pos_wide[IW-1:0];
                        count_next = count_reg + CW'(1);
                    end
                end
                olis_pkg::ACT_SEARCH:
                begin
                    scan_start     = 1'b1;
                    state_next     = ST_SCAN;
                    out_valid_next = 1'b0;
                end
                default:
                begin
                end
            endcase
            len_next = len_now;
        end
        else if (state_reg == ST_SCAN && scan_stat.done && out_free)
        begin
            status_next    = olis_pkg::ST_OK;
            found_next     = scan_stat.found;
            fidx_next      = scan_stat.found ? idx_wide[5:0] : 6'd0;
            len_next       = len_now;
            out_valid_next = 1'b1;
            state_next     = ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        found_reg  <= found_next;
        fidx_reg   <= fidx_next;
        len_reg    <= len_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.found       = found_reg;
    assign rsp.found_index = fidx_reg;
    assign rsp.length      = len_reg;

    // row of cells, index 0 is the front
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [31:0] left_v;
        logic [31:0] right_v;

        if (i == 0)
        begin : g_first
            assign left_v = '0;
        end
        else
        begin : g_mid_l
            assign left_v = cell_val[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_v = '0;
        end
        else
        begin : g_mid_r
            assign right_v = cell_val[i+1];
        end

        olis_cell #(
            .IDX (i),
            .IW  (IW),
            .CW  (CW)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .pos         (ins_pos),
            .count       (count_reg),
            .new_value   (req.value),
            .left_value  (left_v),
            .right_value (right_v),
            .key         (req.value),
            .value       (cell_val[i]),
            .match       (match_vec[i])
        );
    end

    olis_scan #(
        .CAPACITY (CAPACITY),
        .NG       (NG),
        .GW       (GW)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scan_start),
        .run   (state_reg == ST_SCAN),
        .match (match_vec),
        .stat  (scan_stat),
        .index (scan_idx)
    );

endmodule

[design/olis_cell.sv]
// one list entry: shifts with its neighbors and compares against the key
module olis_cell #(
    parameter int IDX = 0,
    parameter int IW  = 6,
    parameter int CW  = 7
) (
    input  logic                clk,
    input  olis_pkg::cell_cmd_t cmd,
    input  logic [IW-1:0]       pos,
    input  logic [CW-1:0]       count,
    input  logic [31:0]         new_value,
    input  logic [31:0]         left_value,
    input  logic [31:0]         right_value,
    input  logic [31:0]         key,
    output logic [31:0]         value,
    output logic                match
);

    localparam logic [IW-1:0] MY_POS  = IW'(IDX);
    localparam logic [CW-1:0] MY_CNT  = CW'(IDX);
    localparam logic [CW-1:0] NEXT_CNT = CW'(IDX + 1);

    logic [31:0] value_reg;
    logic [31:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (cmd.ins)
        begin
            if (pos == MY_POS)
            begin
                value_next = new_value;
            end
            else if (pos < MY_POS && MY_CNT <= count)
            begin
                value_next = left_value;
            end
        end
        else if (cmd.drop_head)
        begin
            if (NEXT_CNT < count)
            begin
                value_next = right_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign match = (value_reg == key) && (MY_CNT < count);

endmodule

[design/olis_scan.sv]
// first-match finder: walks the match vector one group of eight per cycle
module olis_scan #(
    parameter int CAPACITY = 64,
    parameter int NG       = 8,
    parameter int GW       = 3
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   run,
    input  logic [CAPACITY-1:0]    match,
    output olis_pkg::scan_stat_t   stat,
    output logic [GW+2:0]          index
);

    localparam int VW = NG * olis_pkg::GROUP_W;
    localparam logic [GW-1:0] LAST_GRP = GW'(NG - 1);

    logic [VW-1:0] vec_reg;
    logic [VW-1:0] vec_next;
    logic [GW-1:0] grp_reg;
    logic [GW-1:0] grp_next;
    logic [2:0]    enc;
    logic          hit;

    always_comb
    begin
        enc = 3'd0;
        hit = 1'b0;
        for (int b = olis_pkg::GROUP_W - 1; b >= 0; b--)
        begin
            if (vec_reg[b])
            begin
                enc = 3'(b);
                hit = 1'b1;
            end
        end
    end

    assign stat.found = hit;
    assign stat.done  = hit || (grp_reg == LAST_GRP);
    assign index      = {grp_reg, enc};

    always_comb
    begin
        vec_next = vec_reg;
        grp_next = grp_reg;
        if (start)
        begin
            vec_next = VW'(match);
            grp_next = '0;
        end
        else if (run && !stat.done)
        begin
            vec_next = vec_reg >> olis_pkg::GROUP_W;
            grp_next = grp_reg + GW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_reg <= '0;
            grp_reg <= '0;
        end
        else
        begin
            vec_reg <= vec_next;
            grp_reg <= grp_next;
        end
    end

endmodule
